// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lsss_pkg.sv =====
// ----------------------------------------------------------------------------
// lsss_pkg
// Types, constants and helpers shared by the stride search modules.
// ----------------------------------------------------------------------------
package lsss_pkg;

  localparam int unsigned STRIDE_W   = 21;
  localparam int unsigned STRIDE_MAX = 2097151;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_AREA,
    OP_D0_START,
    OP_D0_DONE,
    OP_COP_START,
    OP_GCD_DIV,
    OP_GCD_STEP,
    OP_D_STEP,
    OP_SET_ERR,
    OP_BAS_DIV,
    OP_BAS_INC,
    OP_BAS_SET,
    OP_K_STEP,
    OP_MUL_UU,
    OP_MUL_VV,
    OP_MUL_UV,
    OP_CAP_L1,
    OP_CAP_L2,
    OP_SWAP,
    OP_CAP_NUM,
    OP_Q_DIV,
    OP_CAP_Q,
    OP_MUL_QX,
    OP_SUB_X,
    OP_MUL_QY,
    OP_SUB_Y_SWAP,
    OP_CAP_DOT,
    OP_MUL_ANG,
    OP_MUL_RATIO,
    OP_WIN,
    OP_NEXT,
    OP_FIN
  } op_e;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic trials_zero;
    logic d_over;
    logic b_zero;
    logic a_one;
    logic w_zero;
    logic rem_zero;
    logic inc;
    logic k_limit;
    logic wrap;
    logic l2_lt_l1;
    logic l2_gt_l1;
    logic l2_zero;
    logic neg;
    logic have;
  } stat_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    return m;
  endfunction

endpackage

// ===== sv/lsss_mul.sv =====
// ----------------------------------------------------------------------------
// lsss_mul
// Sequential signed two-term product a0*b0 + a1*b1, exact to 128 bits.
// One 32x32 partial product per cycle, eight partial products per request.
// ----------------------------------------------------------------------------
module lsss_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [63:0]  a0_i,
  input  logic signed [63:0]  b0_i,
  input  logic signed [63:0]  a1_i,
  input  logic signed [63:0]  b1_i,
  output logic                done_o,
  output logic signed [127:0] prod_o
);
  import lsss_pkg::*;

  logic [63:0]  ma0_q, mb0_q, ma1_q, mb1_q;
  logic         sg0_q, sg1_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [127:0] acc_q;

  logic [63:0]  ma_sel, mb_sel, pp;
  logic [31:0]  a_half, b_half;
  logic [127:0] ppw, addend;
  logic         sg_sel;

  assign ma_sel = cnt_q[2] ? ma1_q : ma0_q;
  assign mb_sel = cnt_q[2] ? mb1_q : mb0_q;
  assign sg_sel = cnt_q[2] ? sg1_q : sg0_q;
  assign a_half = cnt_q[1] ? ma_sel[63:32] : ma_sel[31:0];
  assign b_half = cnt_q[0] ? mb_sel[63:32] : mb_sel[31:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (cnt_q[1:0])
      2'b00:   ppw = {64'd0, pp};
      2'b11:   ppw = {pp, 64'd0};
      default: ppw = {32'd0, pp, 32'd0};
    endcase
    addend = sg_sel ? -ppw : ppw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma0_q <= mag64(a0_i);
      mb0_q <= mag64(b0_i);
      ma1_q <= mag64(a1_i);
      mb1_q <= mag64(b1_i);
      sg0_q <= a0_i[63] ^ b0_i[63];
      sg1_q <= a1_i[63] ^ b1_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
    end
  end

  assign done_o = done_q;
  assign prod_o = $signed(acc_q);

endmodule

// ===== sv/lsss_div.sv =====
// ----------------------------------------------------------------------------
// lsss_div
// Sequential signed 64-bit division, truncating toward zero.
// Restoring radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsss_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quot_o,
  output logic signed [63:0] rem_o
);
  import lsss_pkg::*;

  logic [63:0] quo_q, rem_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, nq_q, nr_q;

  logic [64:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag64(num_i);
      den_q <= mag64(den_i);
      rem_q <= '0;
      nq_q  <= num_i[63] ^ den_i[63];
      nr_q  <= num_i[63];
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : trial[63:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q ? -$signed(quo_q) : $signed(quo_q);
  assign rem_o  = nr_q ? -$signed(rem_q) : $signed(rem_q);

endmodule

// ===== sv/lsss_dp.sv =====
// ----------------------------------------------------------------------------
// lsss_dp
// Datapath: request registers, stride and gcd registers, lattice basis,
// Gauss reduction and score registers around a shared multiplier and divider.
// ----------------------------------------------------------------------------
module lsss_dp #(
  parameter int unsigned MAX_DIM         = 1024,
  parameter int unsigned BASIS_TRY_LIMIT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lsss_pkg::op_e                   op_i,
  input  logic [10:0]                     grid_width_i,
  input  logic [10:0]                     grid_height_i,
  input  logic [20:0]                     sample_count_i,
  input  logic [7:0]                      trial_limit_i,
  output lsss_pkg::stat_t                 stat_o,
  output logic [lsss_pkg::STRIDE_W-1:0]   best_stride_o,
  output logic                            search_error_o
);
  import lsss_pkg::*;

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned AREA_W = 2 * DIM_W;
  localparam int unsigned D_W    = ((AREA_W > STRIDE_W) ? AREA_W : STRIDE_W) + 1;
  localparam int unsigned K_W    = $clog2(BASIS_TRY_LIMIT + 2);

  logic [DIM_W-1:0]    w_q, h_q;
  logic [20:0]         s_q;
  logic [7:0]          trials_q;
  logic [AREA_W-1:0]   area_q;
  logic [D_W-1:0]      d_q, best_q, ga_q, gb_q;
  logic [K_W-1:0]      k_q;
  logic                inc_q, err_q, have_q;
  logic signed [63:0]  ux_q, uy_q, vx_q, vy_q;
  logic signed [63:0]  l1_q, l2_q, num_q, q_q, adot_q, bl1_q, bl2_q;
  logic [STRIDE_W-1:0] out_stride_q;
  logic                out_err_q;

  logic                even;
  logic [D_W-1:0]      stepv, d0v;
  logic signed [63:0]  w64, sx;
  logic signed [63:0]  m_a0, m_b0, m_a1, m_b1, dv_num, dv_den;
  logic                mul_start, div_start, mul_done, div_done;
  logic signed [127:0] prod;
  logic signed [63:0]  quot, rem, plo, dotmag;

  assign even  = ~area_q[0];
  assign stepv = even ? D_W'(2) : D_W'(1);
  assign w64   = $signed(64'(w_q));
  assign sx    = vx_q + ux_q;
  assign plo   = prod[63:0];
  assign dotmag = $signed(mag64(plo));
  assign d0v   = quot[D_W-1:0];

  always_comb begin
    m_a0 = '0;
    m_b0 = '0;
    m_a1 = '0;
    m_b1 = '0;
    case (op_i)
      OP_MUL_UU: begin
        m_a0 = ux_q; m_b0 = ux_q; m_a1 = uy_q; m_b1 = uy_q;
      end
      OP_MUL_VV: begin
        m_a0 = vx_q; m_b0 = vx_q; m_a1 = vy_q; m_b1 = vy_q;
      end
      OP_MUL_UV: begin
        m_a0 = ux_q; m_b0 = vx_q; m_a1 = uy_q; m_b1 = vy_q;
      end
      OP_MUL_QX: begin
        m_a0 = q_q; m_b0 = vx_q;
      end
      OP_MUL_QY: begin
        m_a0 = q_q; m_b0 = vy_q;
      end
      OP_MUL_ANG: begin
        m_a0 = adot_q; m_b0 = adot_q; m_a1 = -l1_q; m_b1 = l2_q;
      end
      OP_MUL_RATIO: begin
        m_a0 = bl1_q; m_b0 = l2_q; m_a1 = -l1_q; m_b1 = bl2_q;
      end
      default: ;
    endcase
  end

  assign mul_start = (op_i == OP_MUL_UU) || (op_i == OP_MUL_VV) || (op_i == OP_MUL_UV) ||
                     (op_i == OP_MUL_QX) || (op_i == OP_MUL_QY) ||
                     (op_i == OP_MUL_ANG) || (op_i == OP_MUL_RATIO);

  always_comb begin
    dv_num = '0;
    dv_den = '0;
    case (op_i)
      OP_D0_START: begin
        dv_num = $signed(64'(area_q) + 64'(s_q) - 64'd1);
        dv_den = $signed(64'(s_q));
      end
      OP_GCD_DIV: begin
        dv_num = $signed(64'(ga_q));
        dv_den = $signed(64'(gb_q));
      end
      OP_BAS_DIV: begin
        dv_num = $signed(64'(d_q) + 64'(inc_q));
        dv_den = w64;
      end
      OP_Q_DIV: begin
        dv_num = (num_q <<< 1) + l2_q;
        dv_den = l2_q <<< 1;
      end
      default: ;
    endcase
  end

  assign div_start = (op_i == OP_D0_START) || (op_i == OP_GCD_DIV) ||
                     (op_i == OP_BAS_DIV) || (op_i == OP_Q_DIV);

  lsss_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a0_i    (m_a0),
    .b0_i    (m_b0),
    .a1_i    (m_a1),
    .b1_i    (m_b1),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  lsss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (div_done),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        w_q      <= (32'(grid_width_i) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(grid_width_i);
        h_q      <= (32'(grid_height_i) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(grid_height_i);
        s_q      <= (sample_count_i == 21'd0) ? 21'd1 : sample_count_i;
        trials_q <= trial_limit_i;
        err_q    <= 1'b0;
        have_q   <= 1'b0;
      end
      OP_AREA: area_q <= AREA_W'(w_q * h_q);
      OP_D0_DONE: begin
        d_q    <= (even && !d0v[0]) ? d0v + D_W'(1) : d0v;
        best_q <= (even && !d0v[0]) ? d0v + D_W'(1) : d0v;
      end
      OP_COP_START: begin
        ga_q  <= D_W'(area_q);
        gb_q  <= d_q;
        inc_q <= 1'b0;
      end
      OP_GCD_STEP: begin
        ga_q <= gb_q;
        gb_q <= rem[D_W-1:0];
      end
      OP_D_STEP:  d_q   <= d_q + stepv;
      OP_SET_ERR: err_q <= 1'b1;
      OP_BAS_INC: inc_q <= 1'b1;
      OP_BAS_SET: begin
        ux_q <= rem;
        uy_q <= quot;
        vx_q <= rem;
        vy_q <= quot;
        k_q  <= K_W'(1);
      end
      OP_K_STEP: begin
        k_q <= k_q + K_W'(1);
        if (sx >= w64) begin
          vx_q <= sx - w64;
          vy_q <= vy_q + uy_q + 64'sd1;
        end else begin
          vx_q <= sx;
          vy_q <= vy_q + uy_q;
        end
      end
      OP_CAP_L1: l1_q <= plo;
      OP_CAP_L2: l2_q <= plo;
      OP_SWAP: begin
        ux_q <= vx_q;
        uy_q <= vy_q;
        vx_q <= ux_q;
        vy_q <= uy_q;
        l1_q <= l2_q;
        l2_q <= l1_q;
      end
      OP_CAP_NUM: num_q <= plo;
      OP_CAP_Q:   q_q   <= quot;
      OP_SUB_X:   ux_q  <= ux_q - plo;
      OP_SUB_Y_SWAP: begin
        ux_q <= vx_q;
        uy_q <= vy_q;
        vx_q <= ux_q;
        vy_q <= uy_q - plo;
        l1_q <= l2_q;
      end
      OP_CAP_DOT: adot_q <= dotmag <<< 2;
      OP_WIN: begin
        have_q <= 1'b1;
        bl1_q  <= l1_q;
        bl2_q  <= l2_q;
        best_q <= d_q;
      end
      OP_NEXT: begin
        d_q      <= d_q + stepv;
        trials_q <= trials_q - 8'd1;
      end
      OP_FIN: begin
        if (64'(best_q) > 64'(STRIDE_MAX)) begin
          out_stride_q <= STRIDE_W'(STRIDE_MAX);
          out_err_q    <= 1'b1;
        end else begin
          out_stride_q <= best_q[STRIDE_W-1:0];
          out_err_q    <= err_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.mul_done    = mul_done;
    stat_o.div_done    = div_done;
    stat_o.trials_zero = (trials_q == 8'd0);
    stat_o.d_over      = (64'(d_q) > 64'(STRIDE_MAX));
    stat_o.b_zero      = (gb_q == '0);
    stat_o.a_one       = (ga_q == D_W'(1));
    stat_o.w_zero      = (w_q == '0);
    stat_o.rem_zero    = (rem == 64'sd0);
    stat_o.inc         = inc_q;
    stat_o.k_limit     = (k_q == K_W'(BASIS_TRY_LIMIT + 1));
    stat_o.wrap        = (sx >= w64);
    stat_o.l2_lt_l1    = (l2_q < l1_q);
    stat_o.l2_gt_l1    = (l2_q > l1_q);
    stat_o.l2_zero     = (l2_q == 64'sd0);
    stat_o.neg         = prod[127];
    stat_o.have        = have_q;
  end

  assign best_stride_o  = out_stride_q;
  assign search_error_o = out_err_q;

endmodule

// ===== sv/lsss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsss_ctrl
// Sequencer for the stride search: issues one datapath operation per cycle
// and waits on the shared multiplier and divider.
// ----------------------------------------------------------------------------
module lsss_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_ready_i,
  input  lsss_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output lsss_pkg::op_e   op_o
);
  import lsss_pkg::*;

  typedef enum logic [34:0] {
    ST_IDLE  = 35'd1 << 0,
    ST_AREA  = 35'd1 << 1,
    ST_D0    = 35'd1 << 2,
    ST_D0W   = 35'd1 << 3,
    ST_TRIAL = 35'd1 << 4,
    ST_COP   = 35'd1 << 5,
    ST_GCD   = 35'd1 << 6,
    ST_GCDW  = 35'd1 << 7,
    ST_BAS   = 35'd1 << 8,
    ST_BASW  = 35'd1 << 9,
    ST_KSTEP = 35'd1 << 10,
    ST_G0    = 35'd1 << 11,
    ST_G0W   = 35'd1 << 12,
    ST_G1    = 35'd1 << 13,
    ST_G1W   = 35'd1 << 14,
    ST_GS    = 35'd1 << 15,
    ST_GL    = 35'd1 << 16,
    ST_GNW   = 35'd1 << 17,
    ST_GQ    = 35'd1 << 18,
    ST_GDW   = 35'd1 << 19,
    ST_GX    = 35'd1 << 20,
    ST_GXW   = 35'd1 << 21,
    ST_GY    = 35'd1 << 22,
    ST_GYW   = 35'd1 << 23,
    ST_GV    = 35'd1 << 24,
    ST_GVW   = 35'd1 << 25,
    ST_F0    = 35'd1 << 26,
    ST_F0W   = 35'd1 << 27,
    ST_F1    = 35'd1 << 28,
    ST_F1W   = 35'd1 << 29,
    ST_F2    = 35'd1 << 30,
    ST_F2W   = 35'd1 << 31,
    ST_NX    = 35'd1 << 32,
    ST_FIN   = 35'd1 << 33,
    ST_DONE  = 35'd1 << 34
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NOP;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_AREA;
        end
      end
      ST_AREA: begin
        op_o    = OP_AREA;
        state_d = ST_D0;
      end
      ST_D0: begin
        op_o    = OP_D0_START;
        state_d = ST_D0W;
      end
      ST_D0W: begin
        if (stat_i.div_done) begin
          op_o    = OP_D0_DONE;
          state_d = ST_TRIAL;
        end
      end
      ST_TRIAL: state_d = stat_i.trials_zero ? ST_FIN : ST_COP;
      ST_COP: begin
        if (stat_i.d_over) begin
          op_o    = OP_SET_ERR;
          state_d = ST_FIN;
        end else begin
          op_o    = OP_COP_START;
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (stat_i.b_zero) begin
          if (stat_i.a_one) begin
            state_d = ST_BAS;
          end else begin
            op_o    = OP_D_STEP;
            state_d = ST_COP;
          end
        end else begin
          op_o    = OP_GCD_DIV;
          state_d = ST_GCDW;
        end
      end
      ST_GCDW: begin
        if (stat_i.div_done) begin
          op_o    = OP_GCD_STEP;
          state_d = ST_GCD;
        end
      end
      ST_BAS: begin
        if (stat_i.w_zero) begin
          op_o    = OP_SET_ERR;
          state_d = ST_FIN;
        end else begin
          op_o    = OP_BAS_DIV;
          state_d = ST_BASW;
        end
      end
      ST_BASW: begin
        if (stat_i.div_done) begin
          if (stat_i.rem_zero && !stat_i.inc) begin
            op_o    = OP_BAS_INC;
            state_d = ST_BAS;
          end else begin
            op_o    = OP_BAS_SET;
            state_d = ST_KSTEP;
          end
        end
      end
      ST_KSTEP: begin
        if (stat_i.k_limit) begin
          op_o    = OP_SET_ERR;
          state_d = ST_FIN;
        end else begin
          op_o = OP_K_STEP;
          if (stat_i.wrap) begin
            state_d = ST_G0;
          end
        end
      end
      ST_G0: begin
        op_o    = OP_MUL_UU;
        state_d = ST_G0W;
      end
      ST_G0W: begin
        if (stat_i.mul_done) begin
          op_o    = OP_CAP_L1;
          state_d = ST_G1;
        end
      end
      ST_G1: begin
        op_o    = OP_MUL_VV;
        state_d = ST_G1W;
      end
      ST_G1W: begin
        if (stat_i.mul_done) begin
          op_o    = OP_CAP_L2;
          state_d = ST_GS;
        end
      end
      ST_GS: begin
        if (stat_i.l2_gt_l1) begin
          op_o = OP_SWAP;
        end
        state_d = ST_GL;
      end
      ST_GL: begin
        if (!stat_i.l2_lt_l1 || stat_i.l2_zero) begin
          state_d = ST_F0;
        end else begin
          op_o    = OP_MUL_UV;
          state_d = ST_GNW;
        end
      end
      ST_GNW: begin
        if (stat_i.mul_done) begin
          op_o    = OP_CAP_NUM;
          state_d = ST_GQ;
        end
      end
      ST_GQ: begin
        op_o    = OP_Q_DIV;
        state_d = ST_GDW;
      end
      ST_GDW: begin
        if (stat_i.div_done) begin
          op_o    = OP_CAP_Q;
          state_d = ST_GX;
        end
      end
      ST_GX: begin
        op_o    = OP_MUL_QX;
        state_d = ST_GXW;
      end
      ST_GXW: begin
        if (stat_i.mul_done) begin
          op_o    = OP_SUB_X;
          state_d = ST_GY;
        end
      end
      ST_GY: begin
        op_o    = OP_MUL_QY;
        state_d = ST_GYW;
      end
      ST_GYW: begin
        if (stat_i.mul_done) begin
          op_o    = OP_SUB_Y_SWAP;
          state_d = ST_GV;
        end
      end
      ST_GV: begin
        op_o    = OP_MUL_VV;
        state_d = ST_GVW;
      end
      ST_GVW: begin
        if (stat_i.mul_done) begin
          op_o    = OP_CAP_L2;
          state_d = ST_GL;
        end
      end
      ST_F0: begin
        op_o    = OP_MUL_UV;
        state_d = ST_F0W;
      end
      ST_F0W: begin
        if (stat_i.mul_done) begin
          op_o    = OP_CAP_DOT;
          state_d = ST_F1;
        end
      end
      ST_F1: begin
        op_o    = OP_MUL_ANG;
        state_d = ST_F1W;
      end
      ST_F1W: begin
        if (stat_i.mul_done) begin
          if (!stat_i.neg) begin
            state_d = ST_NX;
          end else if (!stat_i.have) begin
            op_o    = OP_WIN;
            state_d = ST_NX;
          end else begin
            state_d = ST_F2;
          end
        end
      end
      ST_F2: begin
        op_o    = OP_MUL_RATIO;
        state_d = ST_F2W;
      end
      ST_F2W: begin
        if (stat_i.mul_done) begin
          if (stat_i.neg) begin
            op_o = OP_WIN;
          end
          state_d = ST_NX;
        end
      end
      ST_NX: begin
        op_o    = OP_NEXT;
        state_d = ST_TRIAL;
      end
      ST_FIN: begin
        op_o    = OP_FIN;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

endmodule

// ===== sv/lattice_sample_stride_search_top.sv =====
// ----------------------------------------------------------------------------
// lattice_sample_stride_search_top
// Picks the sampling stride through a grid whose point lattice is closest
// to square, one request in and one result out.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_axis_tready is high only while idle,
// and the result waits in an output register until taken. Latency is data
// dependent: every division runs on a radix-2 divider, every product on a
// 32x32 multiplier over eight partial products. Per trial, each gcd
// remainder costs one division, the basis search tries one multiplier per
// cycle (up to BASIS_TRY_LIMIT), and each Gauss step costs one division and
// four products. The worst case grows with trial_limit. No start-up sweep
// follows reset.
`include "assert_macros.svh"

module lattice_sample_stride_search_top #(
  parameter int unsigned MAX_DIM         = 1024,
  parameter int unsigned BASIS_TRY_LIMIT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // grid_width[10:0], grid_height[21:11], sample_count[42:22],
  // trial_limit[50:43], zero pad [55:51]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // best_stride[20:0], zero pad [23:21]
  output logic [23:0] m_axis_tdata,
  // search_error[0]
  output logic        m_axis_tuser
);
  import lsss_pkg::*;

  op_e                 op;
  stat_t               stat;
  logic [STRIDE_W-1:0] best_stride;
  logic                search_error;

  lsss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .op_o        (op)
  );

  lsss_dp #(
    .MAX_DIM         (MAX_DIM),
    .BASIS_TRY_LIMIT (BASIS_TRY_LIMIT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .grid_width_i   (s_axis_tdata[10:0]),
    .grid_height_i  (s_axis_tdata[21:11]),
    .sample_count_i (s_axis_tdata[42:22]),
    .trial_limit_i  (s_axis_tdata[50:43]),
    .stat_o         (stat),
    .best_stride_o  (best_stride),
    .search_error_o (search_error)
  );

  assign m_axis_tdata = {3'd0, best_stride};
  assign m_axis_tuser = search_error;

  `ASSERT_SAME(a_no_req_while_result, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "request accepted while result pending")
  `ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "not busy after request")
  `ASSERT_NEXT(a_result_once, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "result delivered twice")

endmodule
